// File: sv/pfb_pkg.sv
`timescale 1ns / 1ps
package pfb_pkg;

	localparam int PANEL_WIDTH_DEF = 128;
	localparam int PANEL_HEIGHT_DEF = 64;
	localparam int GLYPH_DEPTH_DEF = 1024;

	localparam int CELL_W = 7;
	localparam int CELL_H = 10;
	localparam int CODE_FIRST = 32;
	localparam int CODE_LAST = 126;

	localparam logic [2:0] OP_FILL = 3'd0;
	localparam logic [2:0] OP_PIXEL = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_CHAR = 3'd3;
	localparam logic [2:0] OP_LOAD = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	typedef struct packed {
		logic       touch;
		logic [7:0] data;
	} merge_t;

endpackage

// File: sv/pfb_page_merge.sv
`timescale 1ns / 1ps
module pfb_page_merge import pfb_pkg::*; (
	input  logic [CELL_H-1:0] col_bits,
	input  logic [2:0]        row_off,
	input  logic [1:0]        page_sel,
	input  logic [7:0]        old_byte,
	output merge_t            merged
);

	logic [23:0] mask_w;
	logic [23:0] data_w;
	logic [7:0]  mask_b;
	logic [7:0]  data_b;

	always_comb begin
		mask_w = {{(24-CELL_H){1'b0}}, {CELL_H{1'b1}}} << row_off;
		data_w = {{(24-CELL_H){1'b0}}, col_bits} << row_off;
		case (page_sel)
			2'd0: begin
				mask_b = mask_w[7:0];
				data_b = data_w[7:0];
			end
			2'd1: begin
				mask_b = mask_w[15:8];
				data_b = data_w[15:8];
			end
			default: begin
				mask_b = mask_w[23:16];
				data_b = data_w[23:16];
			end
		endcase
		merged.touch = |mask_b;
		merged.data = (old_byte & ~mask_b) | (data_b & mask_b);
	end

endmodule

// File: sv/page_framebuffer_text_renderer.sv
`timescale 1ns / 1ps
// Channel   Handshake              Fields
// request   start, busy            operation, x_coord, y_coord, pixel_value, char_code,
//                                  glyph_index, glyph_word, frame_address
// result    done (one cycle)       read_byte, char_result
//
// A request is taken when start is high and busy is low; one done pulse answers each.
// Cursor, glyph load and rejected requests answer in the cycle after they are taken;
// pixel answers from S_PIX_WR after S_PIX_RD, read from S_RD_OUT after S_RD_ISS.
// A character does ten glyph reads, then one read-modify-write of the frame memory
// for each of the two or three page bytes in each of seven columns. Fill writes one
// frame byte per cycle, FRAME_BYTES in all. Reset clears every byte with busy high.
// The result side cannot stall; done and the result fields hold for one cycle only.
module page_framebuffer_text_renderer import pfb_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
	parameter int GLYPH_STORE_DEPTH = GLYPH_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [7:0]  x_coord,
	input  logic [7:0]  y_coord,
	input  logic        pixel_value,
	input  logic [7:0]  char_code,
	input  logic [9:0]  glyph_index,
	input  logic [15:0] glyph_word,
	input  logic [9:0]  frame_address,
	output logic        done,
	output logic [7:0]  read_byte,
	output logic [7:0]  char_result
);

	localparam int FRAME_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
	localparam int FA_W = $clog2(FRAME_BYTES);
	localparam int GA_W = $clog2(GLYPH_STORE_DEPTH);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CLEAR  = 11'b000_0000_0010,
		S_FILL   = 11'b000_0000_0100,
		S_PIX_RD = 11'b000_0000_1000,
		S_PIX_WR = 11'b000_0001_0000,
		S_RD_ISS = 11'b000_0010_0000,
		S_RD_OUT = 11'b000_0100_0000,
		S_GLY    = 11'b000_1000_0000,
		S_COL_RD = 11'b001_0000_0000,
		S_COL_WR = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [7:0]      cur_col_q;
	logic [7:0]      cur_row_q;
	logic            fill_val_q;
	logic [FA_W-1:0] ptr_q;
	logic [FA_W-1:0] addr_q;
	logic            pix_val_q;
	logic [2:0]      pix_bit_q;
	logic [7:0]      code_q;
	logic [GA_W-1:0] gbase_q;
	logic [3:0]      gissue_q;
	logic            gcap_s1;
	logic [3:0]      grow_s1;
	logic [2:0]      col_q;
	logic [1:0]      page_q;
	logic            done_q;
	logic [7:0]      read_byte_q;
	logic [7:0]      char_result_q;

	logic [CELL_H-1:0] col_bits_q [CELL_W];

	logic [7:0]      fs_mem [FRAME_BYTES];
	logic [7:0]      fs_rd_q;
	logic            fs_re;
	logic            fs_we;
	logic [FA_W-1:0] fs_raddr;
	logic [FA_W-1:0] fs_waddr;
	logic [7:0]      fs_wdata;

	logic [15:0]     gl_mem [GLYPH_STORE_DEPTH];
	logic [15:0]     gl_rd_q;
	logic            gl_re;
	logic            gl_we;
	logic [GA_W-1:0] gl_raddr;
	logic [GA_W-1:0] gl_waddr;

	logic            accept;
	logic [4:0]      page_idx;
	logic [FA_W-1:0] col_addr;
	logic [7:0]      pix_mask;
	logic            last_step;
	logic            char_ok;
	merge_t          merged;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign read_byte = read_byte_q;
	assign char_result = char_result_q;

	assign page_idx = 5'(cur_row_q[7:3]) + 5'(page_q);
	assign col_addr = FA_W'(32'(cur_col_q) + 32'(col_q) + 32'(page_idx) * PANEL_WIDTH);
	assign pix_mask = 8'd1 << pix_bit_q;
	assign last_step = (col_q == 3'(CELL_W - 1)) && (page_q == 2'd2);
	assign char_ok = (32'(char_code) >= CODE_FIRST) && (32'(char_code) <= CODE_LAST) &&
		(32'(cur_col_q) + CELL_W <= PANEL_WIDTH) &&
		(32'(cur_row_q) + CELL_H <= PANEL_HEIGHT);

	pfb_page_merge u_merge (
		.col_bits (col_bits_q[col_q]),
		.row_off  (cur_row_q[2:0]),
		.page_sel (page_q),
		.old_byte (fs_rd_q),
		.merged   (merged)
	);

	always_comb begin
		fs_re = 1'b0;
		fs_we = 1'b0;
		fs_raddr = addr_q;
		fs_waddr = addr_q;
		fs_wdata = fs_rd_q;
		unique case (state_q) inside
			S_CLEAR, S_FILL: begin
				fs_we = 1'b1;
				fs_waddr = ptr_q;
				fs_wdata = {8{fill_val_q}};
			end
			S_PIX_RD, S_RD_ISS: begin
				fs_re = 1'b1;
			end
			S_PIX_WR: begin
				fs_we = 1'b1;
				fs_wdata = pix_val_q ? (fs_rd_q | pix_mask) : (fs_rd_q & ~pix_mask);
			end
			S_COL_RD: begin
				fs_re = merged.touch;
				fs_raddr = col_addr;
			end
			S_COL_WR: begin
				fs_we = 1'b1;
				fs_waddr = col_addr;
				fs_wdata = merged.data;
			end
			default: begin
			end
		endcase
	end

	assign gl_re = (state_q == S_GLY) && (gissue_q < 4'(CELL_H));
	assign gl_raddr = gbase_q + GA_W'(gissue_q);
	assign gl_we = accept && (operation == OP_LOAD) && (32'(glyph_index) < GLYPH_STORE_DEPTH);
	assign gl_waddr = GA_W'(glyph_index);

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		if (fs_re) begin
			fs_rd_q <= fs_mem[fs_raddr];
		end
		if (gl_we) begin
			gl_mem[gl_waddr] <= glyph_word;
		end
		if (gl_re) begin
			gl_rd_q <= gl_mem[gl_raddr];
		end
		if (state_q == S_GLY && gcap_s1) begin
			for (int c = 0; c < CELL_W; c++) begin
				col_bits_q[c][grow_s1] <= gl_rd_q[15 - c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_col_q <= '0;
			cur_row_q <= '0;
			fill_val_q <= 1'b0;
			ptr_q <= '0;
			addr_q <= '0;
			pix_val_q <= 1'b0;
			pix_bit_q <= '0;
			code_q <= '0;
			gbase_q <= '0;
			gissue_q <= '0;
			gcap_s1 <= 1'b0;
			grow_s1 <= '0;
			col_q <= '0;
			page_q <= '0;
			done_q <= 1'b0;
			read_byte_q <= '0;
			char_result_q <= '0;
		end else begin
			done_q <= 1'b0;
			read_byte_q <= '0;
			char_result_q <= '0;
			unique case (state_q) inside
				S_IDLE: begin
					if (start) begin
						case (operation)
							OP_FILL: begin
								fill_val_q <= pixel_value;
								ptr_q <= '0;
								state_q <= S_FILL;
							end
							OP_PIXEL: begin
								if (32'(x_coord) < PANEL_WIDTH &&
										32'(y_coord) < PANEL_HEIGHT) begin
									addr_q <= FA_W'(32'(x_coord) +
										32'(y_coord[7:3]) * PANEL_WIDTH);
									pix_val_q <= pixel_value;
									pix_bit_q <= y_coord[2:0];
									state_q <= S_PIX_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_CURSOR: begin
								cur_col_q <= x_coord;
								cur_row_q <= y_coord;
								done_q <= 1'b1;
							end
							OP_CHAR: begin
								if (char_ok) begin
									code_q <= char_code;
									gbase_q <= GA_W'(32'(char_code - 8'(CODE_FIRST)) *
										CELL_H);
									gissue_q <= '0;
									gcap_s1 <= 1'b0;
									state_q <= S_GLY;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_READ: begin
								if (32'(frame_address) < FRAME_BYTES) begin
									addr_q <= FA_W'(frame_address);
									state_q <= S_RD_ISS;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_CLEAR, S_FILL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == FA_W'(FRAME_BYTES - 1)) begin
						done_q <= (state_q == S_FILL);
						state_q <= S_IDLE;
					end
				end
				S_PIX_RD: begin
					state_q <= S_PIX_WR;
				end
				S_PIX_WR: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD_ISS: begin
					state_q <= S_RD_OUT;
				end
				S_RD_OUT: begin
					read_byte_q <= fs_rd_q;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_GLY: begin
					if (gl_re) begin
						gissue_q <= gissue_q + 1'b1;
					end
					gcap_s1 <= gl_re;
					grow_s1 <= gissue_q;
					if (gcap_s1 && grow_s1 == 4'(CELL_H - 1)) begin
						col_q <= '0;
						page_q <= '0;
						state_q <= S_COL_RD;
					end
				end
				S_COL_RD, S_COL_WR: begin
					if (state_q == S_COL_RD && merged.touch) begin
						state_q <= S_COL_WR;
					end else if (last_step) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_COL_RD;
						if (page_q == 2'd2) begin
							page_q <= '0;
							col_q <= col_q + 1'b1;
						end else begin
							page_q <= page_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					char_result_q <= code_q;
					cur_col_q <= cur_col_q + 8'(CELL_W);
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register is not one-hot");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !fs_we)
		else $error("frame memory written while idle");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COL_WR || state_q == S_PIX_WR) |->
		($past(state_q) == S_COL_RD || $past(state_q) == S_PIX_RD))
		else $error("frame write without a preceding read");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (read_byte == 8'd0 && char_result == 8'd0))
		else $error("result fields active without done");

	a_fill_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_FILL) |=> (state_q == S_FILL))
		else $error("fill request did not start the sweep");
`endif

endmodule

// File: bench/tb_page_framebuffer_text_renderer.sv
`timescale 1ns / 1ps
module tb_page_framebuffer_text_renderer;
	import pfb_pkg::*;

	localparam int PANEL_W = PANEL_WIDTH_DEF;
	localparam int PANEL_H = PANEL_HEIGHT_DEF;
	localparam int GLYPH_DEPTH = GLYPH_DEPTH_DEF;
	localparam int FRAME_BYTES = PANEL_W * ((PANEL_H + 7) / 8);
	localparam int GLYPH_WORDS = (CODE_LAST - CODE_FIRST + 1) * CELL_H;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam int RANDOM_REQUESTS = 280;
	localparam int MAX_GAP = 10;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        value;
		logic [7:0]  code;
		logic [9:0]  gidx;
		logic [15:0] gword;
		logic [9:0]  faddr;
	} frame_request_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [7:0] char_result;
	} frame_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic [7:0] read_byte;
	logic [7:0] char_result;
	frame_request_t active_request = '0;

	frame_request_t pending_requests[$];
	frame_answer_t answers_due[$];

	logic [7:0] frame_model [FRAME_BYTES];
	logic [15:0] glyph_model [GLYPH_DEPTH];
	logic [7:0] model_col;
	logic [7:0] model_row;

	bit request_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int cycle_count = 0;
	int cycle_limit = 0;
	int mismatches = 0;
	int answers_checked = 0;
	int accepted = 0;
	int chars_drawn = 0;
	int op_count [8];

	page_framebuffer_text_renderer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(active_request.op),
		.x_coord(active_request.x),
		.y_coord(active_request.y),
		.pixel_value(active_request.value),
		.char_code(active_request.code),
		.glyph_index(active_request.gidx),
		.glyph_word(active_request.gword),
		.frame_address(active_request.faddr),
		.done(done),
		.read_byte(read_byte),
		.char_result(char_result)
	);

	always #2 clk = ~clk;

	function automatic void paint_pixel(int px, int py, logic lit);
		int addr;
		if (px >= PANEL_W || py >= PANEL_H)
			return;
		addr = px + (py / 8) * PANEL_W;
		frame_model[addr][py % 8] = lit;
	endfunction

	function automatic frame_answer_t predict_frame_op(frame_request_t rq);
		frame_answer_t ans;
		logic [15:0] bits;
		int base;
		ans = '0;
		case (rq.op)
		OP_FILL: begin
			for (int a = 0; a < FRAME_BYTES; a++)
				frame_model[a] = rq.value ? 8'hFF : 8'h00;
		end
		OP_PIXEL: paint_pixel(int'(rq.x), int'(rq.y), rq.value);
		OP_CURSOR: begin
			model_col = rq.x;
			model_row = rq.y;
		end
		OP_CHAR: begin
			if (rq.code >= CODE_FIRST && rq.code <= CODE_LAST &&
					int'(model_col) + CELL_W <= PANEL_W &&
					int'(model_row) + CELL_H <= PANEL_H) begin
				base = (int'(rq.code) - CODE_FIRST) * CELL_H;
				for (int row = 0; row < CELL_H; row++) begin
					bits = glyph_model[base + row];
					for (int col = 0; col < CELL_W; col++)
						paint_pixel(int'(model_col) + col, int'(model_row) + row,
							bits[15 - col]);
				end
				model_col = model_col + 8'(CELL_W);
				ans.char_result = rq.code;
				chars_drawn++;
			end
		end
		OP_LOAD: begin
			if (rq.gidx < GLYPH_DEPTH)
				glyph_model[rq.gidx] = rq.gword;
		end
		OP_READ: begin
			if (rq.faddr < FRAME_BYTES)
				ans.read_byte = frame_model[rq.faddr];
		end
		default: ;
		endcase
		return ans;
	endfunction

	function automatic void queue_op(logic [2:0] op, int a, int b, int c);
		frame_request_t rq;
		int cost;
		rq = {$urandom(), $urandom()};
		rq.op = op;
		cost = 6;
		case (op)
		OP_FILL: begin
			rq.value = a[0];
			cost = FRAME_BYTES + 8;
		end
		OP_PIXEL: begin
			rq.x = 8'(a);
			rq.y = 8'(b);
			rq.value = c[0];
		end
		OP_CURSOR: begin
			rq.x = 8'(a);
			rq.y = 8'(b);
		end
		OP_CHAR: begin
			rq.code = 8'(a);
			cost = 64;
		end
		OP_LOAD: rq.gidx = 10'(a);
		OP_READ: rq.faddr = 10'(a);
		default: ;
		endcase
		pending_requests.push_back(rq);
		cycle_limit += 4 * (cost + MAX_GAP + 2);
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("Mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!start || request_taken)) begin
			if (gap_left > 0 || pending_requests.size() == 0) begin
				start <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				active_request <= pending_requests.pop_front();
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 :
						$urandom_range(1, MAX_GAP);
				end
			end
		end
	end

	always @(posedge clk) begin
		frame_answer_t want;
		if (arst_n) begin
			cycle_count++;
			if (done) begin
				answers_checked++;
				if (answers_due.size() == 0) begin
					note_mismatch($sformatf(
						"result with no request waiting (read_byte %02h, char_result %02h)",
						read_byte, char_result));
				end else begin
					want = answers_due.pop_front();
					if (read_byte !== want.read_byte)
						note_mismatch($sformatf("read_byte expected %02h, got %02h",
							want.read_byte, read_byte));
					if (char_result !== want.char_result)
						note_mismatch($sformatf("char_result expected %02h, got %02h",
							want.char_result, char_result));
				end
			end
			request_taken = start && !busy;
			if (request_taken) begin
				accepted++;
				op_count[active_request.op]++;
				answers_due.push_back(predict_frame_op(active_request));
			end
		end
	end

	initial begin
		int pick;
		int gen_row;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame_model[i] = 8'h00;
		for (int i = 0; i < 8; i++)
			op_count[i] = 0;
		model_col = 8'd0;
		model_row = 8'd0;
		gen_row = 0;
		cycle_limit = 4 * (FRAME_BYTES + 100);

		// Every glyph that a character can use is loaded before any drawing.
		for (int i = 0; i < GLYPH_WORDS; i++)
			queue_op(OP_LOAD, i, 0, 0);

		queue_op(OP_FILL, 0, 0, 0);
		queue_op(OP_READ, 0, 0, 0);
		queue_op(OP_FILL, 1, 0, 0);
		queue_op(OP_READ, FRAME_BYTES - 1, 0, 0);
		queue_op(OP_PIXEL, 0, 0, 0);
		queue_op(OP_PIXEL, PANEL_W - 1, PANEL_H - 1, 0);
		queue_op(OP_PIXEL, PANEL_W, 5, 0);
		queue_op(OP_PIXEL, 5, PANEL_H, 0);
		queue_op(OP_PIXEL, 255, 255, 0);
		queue_op(OP_READ, 0, 0, 0);
		queue_op(OP_READ, FRAME_BYTES - 1, 0, 0);
		queue_op(OP_CURSOR, 0, 0, 0);
		queue_op(OP_CHAR, CODE_FIRST, 0, 0);
		queue_op(OP_CHAR, CODE_LAST, 0, 0);
		queue_op(OP_CHAR, CODE_FIRST - 1, 0, 0);
		queue_op(OP_CHAR, CODE_LAST + 1, 0, 0);
		queue_op(OP_CHAR, 0, 0, 0);
		queue_op(OP_CHAR, 255, 0, 0);
		queue_op(OP_CURSOR, PANEL_W - CELL_W, PANEL_H - CELL_H, 0);
		queue_op(OP_CHAR, 65, 0, 0);
		queue_op(OP_CHAR, 66, 0, 0);
		queue_op(OP_READ, PANEL_W - 1 + (PANEL_H / 8 - 1) * PANEL_W, 0, 0);
		queue_op(OP_CURSOR, 0, PANEL_H - CELL_H + 1, 0);
		queue_op(OP_CHAR, 70, 0, 0);
		queue_op(OP_SPARE_6, 0, 0, 0);
		queue_op(OP_SPARE_7, 0, 0, 0);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				queue_op(OP_FILL, $urandom_range(0, 1), 0, 0);
			end else if (pick < 22) begin
				if ($urandom_range(0, 99) < 85)
					queue_op(OP_PIXEL, $urandom_range(0, PANEL_W - 1),
						$urandom_range(0, PANEL_H - 1), $urandom_range(0, 1));
				else
					queue_op(OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 1));
			end else if (pick < 32) begin
				if ($urandom_range(0, 99) < 80) begin
					gen_row = $urandom_range(0, PANEL_H - CELL_H);
					queue_op(OP_CURSOR, $urandom_range(0, PANEL_W - CELL_W), gen_row, 0);
				end else begin
					gen_row = $urandom_range(0, 255);
					queue_op(OP_CURSOR, $urandom_range(0, 255), gen_row, 0);
				end
			end else if (pick < 62) begin
				if ($urandom_range(0, 99) < 85)
					queue_op(OP_CHAR, $urandom_range(CODE_FIRST, CODE_LAST), 0, 0);
				else
					queue_op(OP_CHAR, $urandom_range(0, 255), 0, 0);
			end else if (pick < 68) begin
				queue_op(OP_LOAD, $urandom_range(0, GLYPH_DEPTH - 1), 0, 0);
			end else if (pick < 98) begin
				// Most reads look at the pages the text cursor has been drawing on.
				if ($urandom_range(0, 99) < 60)
					queue_op(OP_READ, $urandom_range(0, PANEL_W - 1) +
						(((gen_row / 8) + $urandom_range(0, 2)) % (PANEL_H / 8)) * PANEL_W,
						0, 0);
				else
					queue_op(OP_READ, $urandom_range(0, FRAME_BYTES - 1), 0, 0);
			end else begin
				queue_op($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, 0, 0, 0);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while ((pending_requests.size() != 0 || start || answers_due.size() != 0) &&
				cycle_count < cycle_limit)
			@(negedge clk);

		if (cycle_count >= cycle_limit) begin
			$display("Timeout after %0d cycles with %0d requests unsent and %0d results due",
				cycle_count, pending_requests.size(), answers_due.size());
			$display("CHECK FAILED");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (answers_due.size() != 0)
				note_mismatch($sformatf("%0d results never arrived", answers_due.size()));
			$display(
				"Summary: %0d requests taken, %0d results checked, %0d characters drawn, %0d rejected.",
				accepted, answers_checked, chars_drawn, op_count[OP_CHAR] - chars_drawn);
			$display(
				"Summary: %0d fills, %0d pixels, %0d frame reads, %0d glyph loads, %0d mismatches.",
				op_count[OP_FILL], op_count[OP_PIXEL], op_count[OP_READ], op_count[OP_LOAD],
				mismatches);
			if (mismatches == 0)
				$display("CHECK OK");
			else
				$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
